// ===== rtl/core/markup_tag_content_extractor_assert.svh =====
// assertion macros for the markup tag content extractor
`ifndef MARKUP_TAG_CONTENT_EXTRACTOR_ASSERT_SVH
`define MARKUP_TAG_CONTENT_EXTRACTOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MTCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MTCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mtce_pkg.sv =====
// shared types and constants of the markup tag content extractor
`timescale 1ns / 1ps
`default_nettype none

package mtce_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int NAME_COUNT_DEF  = 8;
  localparam int NAME_BYTES_DEF  = 6;

  localparam int NAME_W      = 48;
  localparam int CFG_INDEX_W = 4;
  localparam int TAG_W       = 3;

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // title, h1 .. h6, p
  localparam logic [NAME_W-1:0] NAME_RESET [8] = '{
    48'd435611265396, 48'd12648, 48'd12904, 48'd13160,
    48'd13416, 48'd13672, 48'd13928, 48'd112
  };

  typedef struct packed {
    logic             overflowed;
    logic [7:0]       content_byte;
    logic [TAG_W-1:0] tag_index;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/mtce_ram.sv =====
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none

module mtce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/markup_tag_content_extractor.sv =====
// markup tag content extractor top level
`timescale 1ns / 1ps
`default_nettype none

// Takes one document byte per cycle on the s_axis side and passes out the
// text found inside any of NAME_COUNT configured elements, tagged in tuser
// with the index of the innermost open one; a '<' inside such text comes
// out as a newline. Every byte is parsed in the cycle it is accepted and
// its result, if any, is registered at the output, or in the skid entry if
// that stalls, so the block sustains one byte per clock. A two-entry
// output buffer lets it keep taking bytes while one result waits; it
// stalls only when both are full. The nesting stack lives in a ram with
// the top entry and the one below it held in registers. No clearing pass
// follows reset. The user must write names through the cfg port only
// while the stream is idle; the block does not enforce it. The tlast byte
// resets parser and stack, keeping names and the sticky overflow flag.

module markup_tag_content_extractor #(
  parameter int STACK_DEPTH = mtce_pkg::STACK_DEPTH_DEF,
  parameter int NAME_COUNT  = mtce_pkg::NAME_COUNT_DEF,
  parameter int NAME_BYTES  = mtce_pkg::NAME_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // in_byte
  input  wire logic                            s_axis_tlast,  // end_of_document
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [15:0]                          m_axis_tdata,  // content_byte, nesting_overflowed
  output logic [mtce_pkg::TAG_W-1:0]           m_axis_tuser,  // tag_index
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mtce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mtce_pkg::NAME_W-1:0]     cfg_data
);

  import mtce_pkg::*;

  localparam int IDX_W = (NAME_COUNT > 1) ? $clog2(NAME_COUNT) : 1;
  localparam int POS_W = $clog2(NAME_BYTES + 1);
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_FIRST,
    MODE_OPEN_NAME,
    MODE_END_NAME,
    MODE_SKIP,
    MODE_STRING
  } mode_t;

  function automatic mode_t skip_mode(logic [7:0] c);
    mode_t m;
    if (c == CH_GT) begin
      m = MODE_TEXT;
    end else if (c == CH_QUOTE) begin
      m = MODE_STRING;
    end else begin
      m = MODE_SKIP;
    end
    return m;
  endfunction

  function automatic logic [7:0] name_byte(logic [NAME_W-1:0] nm, logic [POS_W-1:0] pos);
    logic [7:0] r;
    r = '0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (pos == POS_W'(b)) begin
        r = nm[8*b +: 8];
      end
    end
    return r;
  endfunction

  logic [NAME_W-1:0]     tag_name [NAME_COUNT];
  mode_t                 mode, mode_next;
  logic [POS_W-1:0]      pos, pos_next;
  logic [NAME_COUNT-1:0] cand, cand_next;
  logic                  close_cand, close_next;
  logic                  saw_slash, slash_next;
  logic [LVL_W-1:0]      level, level_next;
  logic                  overflow_seen, ovf_next;
  logic [IDX_W-1:0]      top_idx, top_next;
  logic [IDX_W-1:0]      under_idx;

  logic                  accept, emit, push, hit, is_sep, pos_full;
  logic [IDX_W-1:0]      hit_idx;
  logic [7:0]            c;
  logic [7:0]            byte_at [NAME_COUNT];
  logic [NAME_COUNT-1:0] ends_at, match_at;
  result_t               res, skid;
  logic                  skid_valid;
  logic                  res_valid;
  result_t               out_res;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !skid_valid;
  assign cfg_ready     = 1'b1;
  assign c             = s_axis_tdata;
  assign is_sep        = (c == CH_SPACE) || (c == CH_GT);
  assign pos_full      = (pos >= POS_W'(NAME_BYTES));

  always_comb begin
    for (int t = 0; t < NAME_COUNT; t++) begin
      byte_at[t]  = name_byte(tag_name[t], pos);
      ends_at[t]  = pos_full || (byte_at[t] == 8'd0);
      match_at[t] = (byte_at[t] == c);
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int t = 0; t < NAME_COUNT; t++) begin
      if (!hit && cand[t] && ends_at[t]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(t);
      end
    end
  end

  always_comb begin
    mode_next  = mode;
    pos_next   = pos;
    cand_next  = cand;
    close_next = close_cand;
    slash_next = saw_slash;
    level_next = level;
    top_next   = top_idx;
    ovf_next   = overflow_seen;
    push       = 1'b0;
    emit       = 1'b0;
    unique case (mode)
      MODE_TEXT: begin
        emit = (level != '0);
        if (c == CH_LT) begin
          mode_next  = MODE_FIRST;
          pos_next   = '0;
          cand_next  = '1;
          close_next = 1'b0;
        end
      end
      MODE_FIRST, MODE_OPEN_NAME: begin
        if (mode == MODE_FIRST && c == CH_SLASH) begin
          if (level != '0) begin
            mode_next  = MODE_END_NAME;
            close_next = 1'b1;
            pos_next   = '0;
          end else begin
            mode_next = MODE_SKIP;
          end
        end else if (is_sep) begin
          if (hit) begin
            if (level < LVL_W'(STACK_DEPTH)) begin
              push       = 1'b1;
              level_next = level + LVL_W'(1);
              top_next   = hit_idx;
            end else begin
              ovf_next = 1'b1;
            end
          end
          mode_next = skip_mode(c);
        end else if (pos_full) begin
          cand_next = '0;
          mode_next = MODE_OPEN_NAME;
        end else begin
          cand_next = cand & match_at;
          pos_next  = pos + POS_W'(1);
          mode_next = MODE_OPEN_NAME;
        end
      end
      MODE_END_NAME: begin
        if (level == '0) begin
          mode_next = skip_mode(c);
        end else if (is_sep) begin
          if (close_cand && ends_at[top_idx]) begin
            level_next = level - LVL_W'(1);
            top_next   = under_idx;
          end
          mode_next = skip_mode(c);
        end else if (pos_full || !match_at[top_idx]) begin
          close_next = 1'b0;
          mode_next  = skip_mode(c);
        end else begin
          pos_next = pos + POS_W'(1);
        end
      end
      MODE_STRING: begin
        if (saw_slash) begin
          slash_next = 1'b0;
        end else if (c == CH_BSLASH) begin
          slash_next = 1'b1;
        end else if (c == CH_QUOTE) begin
          mode_next = MODE_SKIP;
        end
      end
      default: begin
        mode_next = skip_mode(c);
      end
    endcase
    if (s_axis_tlast) begin
      mode_next  = MODE_TEXT;
      pos_next   = '0;
      cand_next  = '1;
      close_next = 1'b0;
      slash_next = 1'b0;
      level_next = '0;
    end
  end

  assign res.tag_index    = TAG_W'(top_idx);
  assign res.content_byte = (c == CH_LT) ? CH_NL : c;
  assign res.overflowed   = overflow_seen;
  assign res_valid        = accept && emit;

  mtce_ram #(
    .WIDTH (IDX_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (accept && push),
    .waddr (AW'(level)),
    .wdata (hit_idx),
    .raddr (AW'(accept ? level_next - LVL_W'(2) : level - LVL_W'(2))),
    .rdata (under_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NAME_COUNT; t++) begin
        tag_name[t] <= NAME_RESET[t];
      end
      mode          <= MODE_TEXT;
      pos           <= '0;
      cand          <= '1;
      close_cand    <= 1'b0;
      saw_slash     <= 1'b0;
      level         <= '0;
      overflow_seen <= 1'b0;
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < CFG_INDEX_W'(NAME_COUNT)) begin
        tag_name[cfg_index[IDX_W-1:0]] <= cfg_data;
      end
      if (accept) begin
        mode          <= mode_next;
        pos           <= pos_next;
        cand          <= cand_next;
        close_cand    <= close_next;
        saw_slash     <= slash_next;
        level         <= level_next;
        overflow_seen <= ovf_next;
        top_idx       <= top_next;
      end
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tvalid <= skid_valid || res_valid;
        out_res       <= skid_valid ? skid : res;
        skid_valid    <= 1'b0;
      end else if (res_valid) begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_axis_tdata = {7'd0, out_res.overflowed, out_res.content_byte};
  assign m_axis_tuser = out_res.tag_index;

`include "markup_tag_content_extractor_assert.svh"

  `MTCE_ASSERT_NOW(a_skid_behind_main, skid_valid, m_axis_tvalid, "skid holds an item ahead of output")
  `MTCE_ASSERT_NEXT(a_last_idles, accept && s_axis_tlast, level == '0 && mode == MODE_TEXT, "tlast did not idle")
  `MTCE_ASSERT_NEXT(a_overflow_sticky, overflow_seen, overflow_seen, "overflow flag cleared")
  `MTCE_ASSERT_NOW(a_emit_needs_open, res_valid, level != '0 && mode == MODE_TEXT, "content with no open element")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for the markup tag content extractor: tag parsing, nesting and content tagging
`timescale 1ns / 1ps

module tb_top;
  import mtce_pkg::*;

  localparam int REG_TAG_NAME_0 = 0;
  localparam int REG_COUNT      = 8;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_LEN       = 150;

  typedef enum logic [2:0] {
    P_TEXT, P_FIRST, P_OPEN_NAME, P_END_NAME, P_SKIP, P_STRING
  } parse_mode_e;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = 8'h00;   // in_byte
  logic                   s_axis_tlast = 1'b0;    // end_of_document
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [15:0]            m_axis_tdata;           // content_byte, nesting_overflowed
  logic [TAG_W-1:0]       m_axis_tuser;           // tag_index
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [NAME_W-1:0]      cfg_data = '0;

  markup_tag_content_extractor u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // parser mirror
  logic [NAME_W-1:0] names_q [REG_COUNT];
  parse_mode_e       mode_q;
  int unsigned       pos_q;
  logic [7:0]        cand_q;
  logic              close_q;
  logic              esc_q;
  logic [TAG_W-1:0]  nest_q [STACK_DEPTH_DEF];
  int unsigned       level_q;
  logic              ovf_q;

  result_t           content_q [$];
  logic [7:0]        doc_q [$];
  logic [NAME_W-1:0] next_names [REG_COUNT];
  int                error_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                hold_requests = 0;
  int                holds_taken = 0;
  int                hold_cycles = 0;
  string             letters = "ahpt1";
  string             odd_letters = "ahpt1\"\\/";

  function automatic logic [7:0] name_char(input logic [NAME_W-1:0] n, input int unsigned p);
    if (p >= NAME_BYTES_DEF) return 8'h00;
    return n[8*p +: 8];
  endfunction

  function automatic bit name_done(input logic [NAME_W-1:0] n, input int unsigned p);
    return (p >= NAME_BYTES_DEF) || (name_char(n, p) == 8'h00);
  endfunction

  function automatic void clear_parse();
    mode_q  = P_TEXT;
    pos_q   = 0;
    cand_q  = 8'hFF;
    close_q = 1'b0;
    esc_q   = 1'b0;
  endfunction

  function automatic void leave_name(input logic [7:0] c);
    if (c == CH_GT) begin
      mode_q = P_TEXT;
    end else if (c == CH_QUOTE) begin
      mode_q = P_STRING;
      esc_q  = 1'b0;
    end else begin
      mode_q = P_SKIP;
    end
  endfunction

  function automatic void open_name_char(input logic [7:0] c);
    bit claimed;
    claimed = 1'b0;
    mode_q = P_OPEN_NAME;
    if (c == CH_SPACE || c == CH_GT) begin
      for (int t = 0; t < NAME_COUNT_DEF; t++) begin
        if (!claimed && cand_q[t] && name_done(names_q[t], pos_q)) begin
          claimed = 1'b1;
          if (level_q < STACK_DEPTH_DEF) begin
            nest_q[level_q] = TAG_W'(t);
            level_q++;
          end else begin
            ovf_q = 1'b1;
          end
        end
      end
      leave_name(c);
    end else if (pos_q >= NAME_BYTES_DEF) begin
      cand_q = 8'h00;
    end else begin
      for (int t = 0; t < REG_COUNT; t++)
        if (name_char(names_q[t], pos_q) != c) cand_q[t] = 1'b0;
      pos_q++;
    end
  endfunction

  function automatic void end_name_char(input logic [7:0] c);
    logic [NAME_W-1:0] n;
    if (level_q == 0) begin
      leave_name(c);
    end else begin
      n = names_q[nest_q[level_q-1]];
      if (c == CH_SPACE || c == CH_GT) begin
        if (close_q && name_done(n, pos_q)) level_q--;
        leave_name(c);
      end else if (pos_q >= NAME_BYTES_DEF || name_char(n, pos_q) != c) begin
        close_q = 1'b0;
        leave_name(c);
      end else begin
        pos_q++;
      end
    end
  endfunction

  // advance the mirror by one accepted byte, queueing any content it yields
  function automatic void track_byte(input logic [7:0] c, input logic last);
    result_t r;
    case (mode_q)
      P_TEXT: begin
        if (level_q > 0) begin
          r.tag_index    = nest_q[level_q-1];
          r.content_byte = (c == CH_LT) ? CH_NL : c;
          r.overflowed   = ovf_q;
          content_q.push_back(r);
        end
        if (c == CH_LT) begin
          mode_q  = P_FIRST;
          pos_q   = 0;
          cand_q  = 8'hFF;
          close_q = 1'b0;
        end
      end
      P_FIRST: begin
        if (c == CH_SLASH) begin
          if (level_q > 0) begin
            mode_q  = P_END_NAME;
            close_q = 1'b1;
            pos_q   = 0;
          end else begin
            mode_q = P_SKIP;
          end
        end else begin
          open_name_char(c);
        end
      end
      P_OPEN_NAME: open_name_char(c);
      P_END_NAME: end_name_char(c);
      P_STRING: begin
        if (esc_q) esc_q = 1'b0;
        else if (c == CH_BSLASH) esc_q = 1'b1;
        else if (c == CH_QUOTE) mode_q = P_SKIP;
      end
      default: leave_name(c);
    endcase
    if (last) begin
      clear_parse();
      level_q = 0;
    end
  endfunction

  // document builders
  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    return (c == CH_LT) ? 8'h78 : c;
  endfunction

  function automatic void add_name(input int t);
    int p;
    p = 0;
    while (p < NAME_BYTES_DEF && names_q[t][8*p +: 8] != 8'h00) begin
      doc_q.push_back(names_q[t][8*p +: 8]);
      p++;
    end
  endfunction

  function automatic void add_attrs();
    int n;
    n = $urandom_range(0, 6);
    add_text(" k=\"");
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(4))
        0: begin
          doc_q.push_back(CH_BSLASH);
          doc_q.push_back(8'($urandom_range(255)));
        end
        1: doc_q.push_back(CH_GT);
        default: doc_q.push_back(8'($urandom_range(97, 122)));
      endcase
    end
    doc_q.push_back(CH_QUOTE);
  endfunction

  function automatic void build_doc(input int budget);
    int open_tags [$];
    int t;
    int n;
    while (doc_q.size() < budget) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) doc_q.push_back(text_char());
        end
        6, 7, 8, 9: begin
          t = $urandom_range(REG_COUNT - 1);
          doc_q.push_back(CH_LT);
          add_name(t);
          if ($urandom_range(9) == 0) doc_q.push_back(letters[$urandom_range(4)]);
          if ($urandom_range(2) == 0) add_attrs();
          doc_q.push_back(CH_GT);
          open_tags.push_back(t);
        end
        10, 11, 12, 13: begin
          if (open_tags.size() > 0 && $urandom_range(4) != 0) t = open_tags[$];
          else t = $urandom_range(REG_COUNT - 1);
          doc_q.push_back(CH_LT);
          doc_q.push_back(CH_SLASH);
          add_name(t);
          if ($urandom_range(3) == 0) doc_q.push_back(CH_SPACE);
          doc_q.push_back(CH_GT);
          if (open_tags.size() > 0 && open_tags[$] == t) void'(open_tags.pop_back());
        end
        14, 15: begin
          n = $urandom_range(1, 8);
          doc_q.push_back(CH_LT);
          for (int i = 0; i < n; i++) doc_q.push_back(odd_letters[$urandom_range(7)]);
          doc_q.push_back(CH_GT);
        end
        16: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) doc_q.push_back(8'($urandom_range(255)));
        end
        17: begin
          if ($urandom_range(5) == 0) begin
            for (int i = 0; i < STACK_DEPTH_DEF + 2; i++) begin
              t = $urandom_range(REG_COUNT - 1);
              doc_q.push_back(CH_LT);
              add_name(t);
              doc_q.push_back(CH_GT);
              open_tags.push_back(t);
            end
          end
        end
        18: add_text(($urandom_range(1) == 0) ? "<>" : "< >");
        default: begin
          add_text("</");
          doc_q.push_back(letters[$urandom_range(4)]);
          doc_q.push_back(CH_GT);
        end
      endcase
    end
  endfunction

  function automatic logic [NAME_W-1:0] random_name(input int len);
    logic [NAME_W-1:0] v;
    v = '0;
    for (int p = 0; p < len; p++) v[8*p +: 8] = letters[$urandom_range(4)];
    return v;
  endfunction

  // stream and register drivers
  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    track_byte(c, last);
  endtask

  task automatic send_doc();
    foreach (doc_q[i]) send_byte(doc_q[i], i == doc_q.size() - 1);
    doc_q.delete();
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (content_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input int idx, input logic [NAME_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_INDEX_W'(idx);
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < REG_COUNT) names_q[idx] = v;
  endtask

  // every name register, then one out-of-range index that must be ignored
  task automatic load_names();
    for (int i = 0; i < REG_COUNT; i++) cfg_write(REG_TAG_NAME_0 + i, next_names[i]);
    cfg_write(REG_COUNT + $urandom_range(7), NAME_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (error_count < 40)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // receiver, with a long hold started on request
  always @(posedge clk) begin
    if (holds_taken != hold_requests) begin
      holds_taken = hold_requests;
      hold_cycles = HOLD_LEN;
    end
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (content_q.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata, 16'h0);
      end else begin
        want = content_q.pop_front();
        if (m_axis_tuser !== want.tag_index)
          report_mismatch("tag_index", 16'(m_axis_tuser), 16'(want.tag_index));
        if (m_axis_tdata[7:0] !== want.content_byte)
          report_mismatch("content_byte", 16'(m_axis_tdata[7:0]), 16'(want.content_byte));
        if (m_axis_tdata[8] !== want.overflowed)
          report_mismatch("nesting_overflowed", 16'(m_axis_tdata[8]), 16'(want.overflowed));
        if (m_axis_tdata[15:9] !== 7'h00)
          report_mismatch("tdata padding", 16'(m_axis_tdata[15:9]), 16'h0);
      end
    end
  end

  // tests
  task automatic test_tag_basics();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_text("z</p><p a=\"\\\">\"><h1>A</h2></h1>");
    doc_q.push_back(8'h00);
    doc_q.push_back(8'hFF);
    send_doc();
    wait_idle();
  endtask

  // empty names match "<>", lowest index wins, stack overflow, all-ones name
  task automatic test_name_extremes();
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    for (int i = 0; i < REG_COUNT; i++) next_names[i] = '0;
    next_names[REG_COUNT-1] = '1;
    load_names();
    for (int i = 0; i <= STACK_DEPTH_DEF; i++) add_text("<>");
    add_text("q</>");
    doc_q.push_back(CH_LT);
    add_name(REG_COUNT - 1);
    add_text(">r");
    send_doc();
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < REG_COUNT; i++) next_names[i] = NAME_RESET[i];
    load_names();
    add_text("<p>");
    for (int i = 0; i < 40; i++) doc_q.push_back(text_char());
    @(posedge clk);
    hold_requests++;
    send_doc();
    wait_idle();
  endtask

  task automatic test_random_docs();
    int sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int i = 0; i < REG_COUNT; i++) begin
        case (ph)
          0: next_names[i] = NAME_RESET[i];
          1: next_names[i] = random_name(($urandom_range(7) == 0) ? 0 : $urandom_range(1, 3));
          2: next_names[i] = random_name(NAME_BYTES_DEF);
          default: next_names[i] = NAME_W'({$urandom, $urandom});
        endcase
      end
      wait_idle();
      load_names();
      sent = 0;
      while (sent < 160) begin
        build_doc($urandom_range(8, 60));
        sent += doc_q.size();
        send_doc();
      end
    end
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < REG_COUNT; i++) names_q[i] = NAME_RESET[i];
    clear_parse();
    level_q = 0;
    ovf_q   = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_tag_basics();
    test_name_extremes();
    test_backpressure();
    test_random_docs();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mtce_pkg.sv
rtl/core/mtce_ram.sv
rtl/core/markup_tag_content_extractor.sv
tb/tb_top.sv
